// ----- rtl/core/msgfrag_pkg.sv -----
package msgfrag_pkg;

  localparam int unsigned FragMax       = 64;
  localparam int unsigned FragBytesDef  = 64;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned PosW          = $clog2(FragMax + 1);
  localparam int unsigned PadW          = $clog2(FragMax);

  localparam logic [7:0] CtrlFirst = 8'h40;
  localparam logic [7:0] CtrlLast  = 8'h80;

  localparam logic ReqStart   = 1'b0;
  localparam logic ReqPayload = 1'b1;

  typedef enum logic {
    OP_START,
    OP_DATA
  } op_e;

  typedef struct packed {
    op_e             op;
    logic            ctrl_en;
    logic [7:0]      ctrl;
    logic [7:0]      b0;
    logic [7:0]      b1;
    logic            data_fe;
    logic            data_me;
    logic [PadW-1:0] pad_cnt;
  } entry_t;

  function automatic logic [7:0] ctrl_byte(input logic first, input logic [7:0] rem,
                                           input logic [PosW-1:0] frag);
    logic [8:0] hdr;
    logic [8:0] room;
    logic [8:0] size;
    logic [8:0] rem9;
    logic [8:0] cnt;
    logic [7:0] c;
    hdr  = first ? 9'd3 : 9'd1;
    room = 9'(frag) - hdr;
    rem9 = {1'b0, rem};
    size = (rem9 < room) ? rem9 : room;
    cnt  = size + hdr - 9'd1;
    c    = {2'b00, cnt[5:0]};
    if (first) begin
      c = c | CtrlFirst;
    end
    if (rem9 <= room) begin
      c = c | CtrlLast;
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/msgfrag_queue.sv -----
module msgfrag_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/core/msgfrag_front.sv -----
module msgfrag_front #(
  parameter int unsigned FRAG_BYTES = msgfrag_pkg::FragBytesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_kind_i,
  input  logic [7:0]           in_cmd_i,
  input  logic [7:0]           in_len_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 full_i,
  output logic                 push_o,
  output msgfrag_pkg::entry_t  entry_o
);

  import msgfrag_pkg::*;

  localparam logic [PosW-1:0] Frag = PosW'(FRAG_BYTES);

  logic [7:0]      rem_q, rem_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            open_q, open_d;
  logic            first_q, first_d;
  logic            accept;
  logic [PosW-1:0] p1;
  logic [7:0]      rem_n;
  logic [PadW-1:0] pads;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign p1         = ((pos_q == '0) ? PosW'(1) : pos_q) + PosW'(1);
  assign rem_n      = rem_q - 8'd1;
  assign pads       = (p1 < Frag) ? PadW'(Frag - p1) : '0;

  always_comb begin
    rem_d   = rem_q;
    pos_d   = pos_q;
    open_d  = open_q;
    first_d = first_q;
    push_o  = 1'b0;
    entry_o = '{op: OP_DATA, ctrl_en: 1'b0, ctrl: 8'h00, b0: in_byte_i, b1: in_len_i,
                data_fe: 1'b0, data_me: 1'b0, pad_cnt: '0};
    if (accept) begin
      if (in_kind_i == ReqStart) begin
        rem_d   = 8'h00;
        pos_d   = '0;
        open_d  = 1'b0;
        first_d = 1'b1;
        if (in_len_i != 8'h00) begin
          rem_d           = in_len_i;
          open_d          = 1'b1;
          pos_d           = PosW'(3);
          push_o          = 1'b1;
          entry_o.op      = OP_START;
          entry_o.ctrl_en = 1'b1;
          entry_o.ctrl    = ctrl_byte(1'b1, in_len_i, Frag);
          entry_o.b0      = in_cmd_i;
        end
      end else if (open_q && (rem_q != 8'h00)) begin
        push_o          = 1'b1;
        entry_o.ctrl_en = (pos_q == '0);
        entry_o.ctrl    = ctrl_byte(first_q, rem_q, Frag);
        rem_d           = rem_n;
        if (rem_n == 8'h00) begin
          entry_o.data_fe = (p1 >= Frag);
          entry_o.data_me = (p1 >= Frag);
          entry_o.pad_cnt = pads;
          pos_d           = '0;
          open_d          = 1'b0;
          first_d         = 1'b1;
        end else if (p1 >= Frag) begin
          entry_o.data_fe = 1'b1;
          pos_d           = '0;
          first_d         = 1'b0;
        end else begin
          pos_d = p1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= 8'h00;
      pos_q   <= '0;
      open_q  <= 1'b0;
      first_q <= 1'b1;
    end else begin
      rem_q   <= rem_d;
      pos_q   <= pos_d;
      open_q  <= open_d;
      first_q <= first_d;
    end
  end

endmodule

// ----- rtl/core/msgfrag_back.sv -----
module msgfrag_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  msgfrag_pkg::entry_t  q_entry_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           out_data_o,
  output logic [1:0]           out_user_o,
  output logic                 out_last_o
);

  import msgfrag_pkg::*;

  typedef enum logic [1:0] {
    PH_CTRL,
    PH_B0,
    PH_B1,
    PH_PAD
  } phase_e;

  phase_e          phase_q, phase_d, ph;
  logic            fresh_q, fresh_d;
  logic [PadW-1:0] pad_left_q, pad_left_d;
  logic            load;
  logic [7:0]      byte_c;
  logic            fe_c;
  logic            me_c;
  logic            last_c;
  logic            valid_q;
  logic [7:0]      data_q;
  logic [1:0]      user_q;
  logic            last_q;

  assign load = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    if (fresh_q) begin
      ph = (q_entry_i.op == OP_START || q_entry_i.ctrl_en) ? PH_CTRL : PH_B0;
    end else begin
      ph = phase_q;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    pad_left_d = pad_left_q;
    byte_c     = 8'h00;
    fe_c       = 1'b0;
    me_c       = 1'b0;
    last_c     = 1'b0;
    unique case (ph)
      PH_CTRL: begin
        byte_c  = q_entry_i.ctrl;
        phase_d = PH_B0;
      end
      PH_B0: begin
        byte_c = q_entry_i.b0;
        if (q_entry_i.op == OP_START) begin
          phase_d = PH_B1;
        end else begin
          fe_c       = q_entry_i.data_fe;
          me_c       = q_entry_i.data_me;
          last_c     = (q_entry_i.pad_cnt == '0);
          phase_d    = PH_PAD;
          pad_left_d = q_entry_i.pad_cnt;
        end
      end
      PH_B1: begin
        byte_c = q_entry_i.b1;
        last_c = 1'b1;
      end
      PH_PAD: begin
        fe_c       = (pad_left_q == PadW'(1));
        me_c       = (pad_left_q == PadW'(1));
        last_c     = (pad_left_q == PadW'(1));
        pad_left_d = pad_left_q - PadW'(1);
      end
      default: begin
        phase_d = PH_CTRL;
      end
    endcase
    fresh_d = fresh_q;
    if (load) begin
      fresh_d = last_c;
    end
  end

  assign q_pop_o     = load && last_c;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_user_o  = user_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_CTRL;
      fresh_q    <= 1'b1;
      pad_left_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      fresh_q <= fresh_d;
      if (load) begin
        phase_q    <= phase_d;
        pad_left_q <= pad_left_d;
        valid_q    <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= byte_c;
      user_q <= {me_c, fe_c};
      last_q <= last_c;
    end
  end

endmodule

// ----- rtl/core/message_fragmenter_64b.sv -----
// Message fragmenter: takes a start word (command, length) followed by one payload
// word per byte and emits fragments of FRAG_BYTES bytes, one byte per output word.
// Each fragment opens with a control byte (bit 6 first, bit 7 last, low six bits the
// count of bytes after it); the first fragment adds the command and length, and the
// last one is zero padded to full size. A start word yields 3 output words, a payload
// word 1 or 2, and the final payload word of a message up to FRAG_BYTES. Input
// words are taken every cycle while the QUEUE_DEPTH-entry queue between the
// classifier and the byte sequencer has room; the sequencer drains it at one byte
// per cycle unless stalled, so sustained input rate is set by output bytes per word.
// Zero-length starts and payload words with no open message produce nothing.
module message_fragmenter_64b #(
  parameter int unsigned FRAG_BYTES  = msgfrag_pkg::FragBytesDef,
  parameter int unsigned QUEUE_DEPTH = msgfrag_pkg::QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // command_id, message_length, payload_byte
  input  logic        s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // frag_byte
  output logic [1:0]  m_axis_tuser,  // fragment_end, message_end
  output logic        m_axis_tlast   // run_last
);

  import msgfrag_pkg::*;

  entry_t push_entry;
  entry_t head_entry;
  logic   push;
  logic   full;
  logic   head_valid;
  logic   pop;

  msgfrag_front #(
    .FRAG_BYTES(FRAG_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .in_kind_i (s_axis_tuser),
    .in_cmd_i  (s_axis_tdata[7:0]),
    .in_len_i  (s_axis_tdata[15:8]),
    .in_byte_i (s_axis_tdata[23:16]),
    .full_i    (full),
    .push_o    (push),
    .entry_o   (push_entry)
  );

  msgfrag_queue #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(head_valid),
    .data_o (head_entry)
  );

  msgfrag_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (head_valid),
    .q_entry_i  (head_entry),
    .q_pop_o    (pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .out_last_o (m_axis_tlast)
  );

endmodule

// ----- rtl/core/msgfrag_checker.sv -----
module msgfrag_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("message end without fragment end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("message end not on last word of its item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] && !m_axis_tuser[1] |-> m_axis_tlast)
    else $error("mid-message fragment end not on last word of its item");

endmodule

bind message_fragmenter_64b msgfrag_checker u_msgfrag_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
